@@ rtl/core/binary_to_decimal_ascii_core_assert.svh @@
// Assertion macros shared by the queue and back modules.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define B2DA_ASSERT(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) \
    else $error("b2da assertion failed");

`define B2DA_NEVER(label, clock, reset, cond) \
  label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
    else $error("b2da forbidden condition seen");

`else

`define B2DA_ASSERT(label, clock, reset, prop)

`define B2DA_NEVER(label, clock, reset, cond)

`endif

`endif

@@ rtl/core/b2da_pkg.sv @@
package b2da_pkg;

  localparam int ValueWidth  = 16;
  localparam int DigitCount  = 5;
  localparam int BcdWidth    = 4 * DigitCount;
  localparam int BitsPerStep = 4;
  localparam int ConvSteps   = ValueWidth / BitsPerStep;
  localparam int StepWidth   = $clog2(ConvSteps);
  localparam int QueueDepth  = 2;

  localparam logic [7:0] CharZero = 8'd48;
  localparam logic [7:0] CharLf   = 8'd10;
  localparam logic [7:0] CharCr   = 8'd13;

  // Character positions within a run: 0..4 are digit slots, then LF and CR.
  localparam logic [2:0] PosLf = 3'd5;
  localparam logic [2:0] PosCr = 3'd6;

  typedef struct packed {
    logic [BcdWidth-1:0] digits;
    logic [2:0]          first;
  } entry_t;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_CONV,
    FRONT_DONE
  } front_state_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_EMIT
  } back_state_t;

  // One shift-and-add-3 step of the binary to BCD conversion.
  function automatic logic [BcdWidth-1:0] dabble_step(input logic [BcdWidth-1:0] bcd,
                                                     input logic in_bit);
    logic [BcdWidth-1:0] adj;
    adj = bcd;
    for (int d = 0; d < DigitCount; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BcdWidth-2:0], in_bit};
  endfunction

  // Slot of the most significant nonzero digit; the units slot for zero.
  function automatic logic [2:0] first_digit(input logic [BcdWidth-1:0] bcd);
    logic [2:0] pos;
    priority if (bcd[19:16] != 4'd0) pos = 3'd0;
    else if (bcd[15:12] != 4'd0)     pos = 3'd1;
    else if (bcd[11:8] != 4'd0)      pos = 3'd2;
    else if (bcd[7:4] != 4'd0)       pos = 3'd3;
    else                             pos = 3'd4;
    return pos;
  endfunction

endpackage

@@ rtl/core/b2da_front.sv @@
module b2da_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         value_valid,
  output logic                         value_stall,
  input  logic [b2da_pkg::ValueWidth-1:0] value,
  input  logic                         full,
  output logic                         push,
  output b2da_pkg::entry_t             entry
);

  b2da_pkg::front_state_t state, state_next;
  logic [b2da_pkg::ValueWidth-1:0] shift, shift_next;
  logic [b2da_pkg::BcdWidth-1:0]   bcd, bcd_next;
  logic [b2da_pkg::StepWidth-1:0]  step;
  logic                            accept;
  logic                            last_step;

  assign accept    = value_valid && !value_stall;
  assign last_step = (step == b2da_pkg::StepWidth'(b2da_pkg::ConvSteps - 1));

  // Several conversion steps per cycle; the value shifts out MSB first.
  always_comb begin
    logic [b2da_pkg::ValueWidth-1:0] s;
    logic [b2da_pkg::BcdWidth-1:0]   b;
    s = shift;
    b = bcd;
    for (int k = 0; k < b2da_pkg::BitsPerStep; k++) begin
      b = b2da_pkg::dabble_step(b, s[b2da_pkg::ValueWidth-1]);
      s = {s[b2da_pkg::ValueWidth-2:0], 1'b0};
    end
    shift_next = s;
    bcd_next   = b;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      b2da_pkg::FRONT_IDLE: begin
        if (accept) state_next = b2da_pkg::FRONT_CONV;
      end
      b2da_pkg::FRONT_CONV: begin
        if (last_step) state_next = b2da_pkg::FRONT_DONE;
      end
      b2da_pkg::FRONT_DONE: begin
        if (!full) state_next = accept ? b2da_pkg::FRONT_CONV : b2da_pkg::FRONT_IDLE;
      end
      default: state_next = b2da_pkg::FRONT_IDLE;
    endcase
  end

  always_comb begin
    push         = (state == b2da_pkg::FRONT_DONE) && !full;
    value_stall  = !((state == b2da_pkg::FRONT_IDLE) ||
                     ((state == b2da_pkg::FRONT_DONE) && !full));
    entry.digits = bcd;
    entry.first  = b2da_pkg::first_digit(bcd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b2da_pkg::FRONT_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        step <= '0;
      end else if (state == b2da_pkg::FRONT_CONV) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shift <= value;
      bcd   <= '0;
    end else if (state == b2da_pkg::FRONT_CONV) begin
      shift <= shift_next;
      bcd   <= bcd_next;
    end
  end

endmodule

@@ rtl/core/b2da_queue.sv @@
`include "binary_to_decimal_ascii_core_assert.svh"

module b2da_queue #(
  parameter int Depth = b2da_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b2da_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output b2da_pkg::entry_t head
);

  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntWidth = $clog2(Depth + 1);

  b2da_pkg::entry_t    mem [Depth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;

  function automatic logic [PtrWidth-1:0] ptr_inc(input logic [PtrWidth-1:0] p);
    return (p == PtrWidth'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count == CntWidth'(Depth));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `B2DA_NEVER(a_queue_no_overflow, clk, rst, push && full)
  `B2DA_NEVER(a_queue_no_underflow, clk, rst, pop && !head_valid)
  `B2DA_ASSERT(a_queue_count_bound, clk, rst, count <= CntWidth'(Depth))

endmodule

@@ rtl/core/b2da_back.sv @@
`include "binary_to_decimal_ascii_core_assert.svh"

module b2da_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  b2da_pkg::entry_t head,
  output logic             pop,
  output logic             char_valid,
  input  logic             char_stall,
  output logic [7:0]       character,
  output logic             last
);

  b2da_pkg::back_state_t         state, state_next;
  logic [b2da_pkg::BcdWidth-1:0] digits;
  logic [2:0]                    pos;
  logic                          load_out;
  logic                          emit_cr;
  logic [7:0]                    cur_char;

  always_comb begin
    state_next = state;
    unique case (state)
      b2da_pkg::BACK_IDLE: begin
        if (pop) state_next = b2da_pkg::BACK_EMIT;
      end
      b2da_pkg::BACK_EMIT: begin
        if (emit_cr && !pop) state_next = b2da_pkg::BACK_IDLE;
      end
      default: state_next = b2da_pkg::BACK_IDLE;
    endcase
  end

  always_comb begin
    load_out = !char_valid || !char_stall;
    emit_cr  = (state == b2da_pkg::BACK_EMIT) && load_out && (pos == b2da_pkg::PosCr);
    // The next run is loaded in the same cycle that the carriage return goes out.
    pop      = head_valid && ((state == b2da_pkg::BACK_IDLE) || emit_cr);
    unique case (pos)
      3'd0:               cur_char = b2da_pkg::CharZero + {4'd0, digits[19:16]};
      3'd1:               cur_char = b2da_pkg::CharZero + {4'd0, digits[15:12]};
      3'd2:               cur_char = b2da_pkg::CharZero + {4'd0, digits[11:8]};
      3'd3:               cur_char = b2da_pkg::CharZero + {4'd0, digits[7:4]};
      3'd4:               cur_char = b2da_pkg::CharZero + {4'd0, digits[3:0]};
      b2da_pkg::PosLf:    cur_char = b2da_pkg::CharLf;
      default:            cur_char = b2da_pkg::CharCr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= b2da_pkg::BACK_IDLE;
      char_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) char_valid <= (state == b2da_pkg::BACK_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      digits <= head.digits;
      pos    <= head.first;
    end else if ((state == b2da_pkg::BACK_EMIT) && load_out) begin
      pos <= pos + 1'b1;
    end
    if ((state == b2da_pkg::BACK_EMIT) && load_out) begin
      character <= cur_char;
      last      <= (pos == b2da_pkg::PosCr);
    end
  end

  `B2DA_ASSERT(a_back_last_is_cr, clk, rst,
               (char_valid && last) |-> (character == b2da_pkg::CharCr))
  `B2DA_ASSERT(a_back_pos_bound, clk, rst,
               (state == b2da_pkg::BACK_EMIT) |-> (pos <= b2da_pkg::PosCr))
  `B2DA_ASSERT(a_back_idle_after_cr, clk, rst,
               (emit_cr && !pop) |=> (state == b2da_pkg::BACK_IDLE))

endmodule

@@ rtl/core/binary_to_decimal_ascii_core.sv @@
// Channel    | Direction | Handshake                  | Payload
// value      | in        | value_valid / value_stall  | value[15:0]
// character  | out       | char_valid / char_stall    | character[7:0], last
//
// The front converts a value to BCD four bits per cycle, taking a new value
// only when idle or as it pushes a result; a two-entry queue feeds the back.
// The back sends one character per cycle unless stalled, 3 to 7 per value;
// a value passes the front, the queue and the back's output register before
// its first character leaves. Reset is synchronous and empties both sides;
// a stalled output holds its character while the front keeps working.
module binary_to_decimal_ascii_core #(
  parameter int QueueDepth = b2da_pkg::QueueDepth
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            value_valid,
  output logic                            value_stall,
  input  logic [b2da_pkg::ValueWidth-1:0] value,
  output logic                            char_valid,
  input  logic                            char_stall,
  output logic [7:0]                      character,
  output logic                            last
);

  b2da_pkg::entry_t push_entry;
  b2da_pkg::entry_t head;
  logic             push;
  logic             full;
  logic             pop;
  logic             head_valid;

  b2da_front u_front (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .full        (full),
    .push        (push),
    .entry       (push_entry)
  );

  b2da_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  b2da_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .character  (character),
    .last       (last)
  );

endmodule

@@ tb/binary_to_decimal_ascii_core_checker.sv @@
`timescale 1ns / 100ps

module binary_to_decimal_ascii_core_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            value_valid,
  input  logic                            value_stall,
  input  logic [b2da_pkg::ValueWidth-1:0] value,
  input  logic                            char_valid,
  input  logic                            char_stall,
  input  logic [7:0]                      character,
  input  logic                            last,
  output int                              mismatches,
  output int                              pending
);

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } ascii_char_t;

  ascii_char_t expected_chars[$];
  int          error_total = 0;

  // Appends the decimal text of one value: digits without leading zeros,
  // then a line feed and a closing carriage return.
  function automatic void queue_decimal_chars(input logic [b2da_pkg::ValueWidth-1:0] v);
    int unsigned rest;
    int unsigned scale;
    int unsigned digit;
    bit          leading;
    rest = v;
    scale = 10000;
    leading = 1'b1;
    for (int pos = 0; pos < b2da_pkg::DigitCount; pos++) begin
      digit = rest / scale;
      rest = rest % scale;
      if (digit != 0 || !leading || scale == 1) begin
        leading = 1'b0;
        expected_chars.push_back('{code: b2da_pkg::CharZero + 8'(digit), last: 1'b0});
      end
      scale = scale / 10;
    end
    expected_chars.push_back('{code: b2da_pkg::CharLf, last: 1'b0});
    expected_chars.push_back('{code: b2da_pkg::CharCr, last: 1'b1});
  endfunction

  always @(posedge clk) begin : check_proc
    ascii_char_t want;
    if (rst) begin
      expected_chars.delete();
    end else begin
      if (value_valid && !value_stall) begin
        queue_decimal_chars(value);
      end
      if (char_valid && !char_stall) begin
        if (expected_chars.size() == 0) begin
          if (error_total < 10) begin
            $display("%0t: character %0d last %0b with no request pending",
                     $time, character, last);
          end
          error_total++;
        end else begin
          want = expected_chars.pop_front();
          if (character !== want.code || last !== want.last) begin
            if (error_total < 10) begin
              $display("%0t: expected character %0d last %0b, got %0d last %0b",
                       $time, want.code, want.last, character, last);
            end
            error_total++;
          end
        end
      end
    end
    mismatches <= error_total;
    pending <= expected_chars.size();
  end

endmodule

@@ tb/binary_to_decimal_ascii_core_test.sv @@
`timescale 1ns / 100ps

module binary_to_decimal_ascii_core_test;

  localparam int RandomItems = 430;
  localparam int QuietFrom   = 380;
  localparam int PauseAt     = 200;
  localparam int HoldAfter   = 60;
  localparam int HoldCycles  = 300;
  localparam int IdleLimit   = 2000;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            value_valid = 1'b0;
  logic [b2da_pkg::ValueWidth-1:0] value = '0;
  logic                            char_stall = 1'b0;
  logic                            quiet = 1'b0;
  logic                            value_stall;
  logic                            char_valid;
  logic [7:0]                      character;
  logic                            last;
  int                              mismatches;
  int                              pending;
  int                              accepted_values = 0;
  int                              idle_cycles = 0;

  binary_to_decimal_ascii_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .value      (value),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .character  (character),
    .last       (last)
  );

  binary_to_decimal_ascii_core_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .value      (value),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .character  (character),
    .last       (last),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (value_valid && !value_stall) begin
      accepted_values <= accepted_values + 1;
    end
    if (rst || (value_valid && !value_stall) || (char_valid && !char_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("binary_to_decimal_ascii_core_test: FAIL");
      $finish;
    end
  end

  // Offers one request and holds it until taken, then optionally idles.
  task automatic send_value(input logic [b2da_pkg::ValueWidth-1:0] v, input int gap);
    value <= v;
    value_valid <= 1'b1;
    do @(posedge clk); while (value_stall);
    if (gap > 0) begin
      value_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Spreads values over every digit count, plus the full 16-bit range.
  function automatic logic [b2da_pkg::ValueWidth-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return b2da_pkg::ValueWidth'($urandom_range(0, 9));
      1: return b2da_pkg::ValueWidth'($urandom_range(10, 99));
      2: return b2da_pkg::ValueWidth'($urandom_range(100, 999));
      3: return b2da_pkg::ValueWidth'($urandom_range(1000, 9999));
      4: return b2da_pkg::ValueWidth'($urandom_range(10000, 65535));
      default: return b2da_pkg::ValueWidth'($urandom);
    endcase
  endfunction

  function automatic int random_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      return $urandom_range(1, 18);
    end
    return 0;
  endfunction

  initial begin : stimulus
    logic [b2da_pkg::ValueWidth-1:0] directed [0:22];
    directed = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
                 16'd9999, 16'd10000, 16'd65535, 16'd65534, 16'd32768, 16'd10101,
                 16'd20000, 16'd1001, 16'd5, 16'd12345, 16'd60000, 16'h5555,
                 16'hAAAA, 16'd100, 16'd7};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[k]) begin
      send_value(directed[k], random_gap());
    end
    for (int i = 0; i < RandomItems; i++) begin
      if (i == PauseAt) begin
        // Let the block drain completely before resuming.
        value_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (i == QuietFrom) begin
        quiet <= 1'b1;
      end
      send_value(random_value(), random_gap());
    end
    value_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("binary_to_decimal_ascii_core_test: PASS");
    end else begin
      $display("binary_to_decimal_ascii_core_test: FAIL");
    end
    $finish;
  end

  initial begin : receiver
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && accepted_values >= HoldAfter) begin
        // One long hold-off so the block fills and pushes back on requests.
        held = 1'b1;
        char_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        char_stall <= 1'b0;
        @(posedge clk);
      end else if (quiet || $urandom_range(0, 3) == 0) begin
        char_stall <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        char_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        char_stall <= 1'b0;
        @(posedge clk);
      end else begin
        char_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

endmodule
